FILE: hw/rtl/scba_pkg.sv
package scba_pkg;

  localparam int unsigned SMALL_BLOCKS_DEF  = 1024;
  localparam int unsigned MEDIUM_BLOCKS_DEF = 128;
  localparam int unsigned LARGE_BLOCKS_DEF  = 16;

  // block sizes are powers of two, kept as shift amounts
  localparam int unsigned SMALL_SHIFT  = 12;
  localparam int unsigned MEDIUM_SHIFT = 16;
  localparam int unsigned LARGE_SHIFT  = 20;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned ROW_W     = IDX_W - BIT_W;
  localparam int unsigned CNT_W     = 13;

  localparam logic [31:0] SMALL_BASE_RST  = 32'd0;
  localparam logic [31:0] MEDIUM_BASE_RST = 32'd4194304;
  localparam logic [31:0] LARGE_BASE_RST  = 32'd12582912;

  localparam logic [1:0] REG_SMALL_BASE  = 2'd0;
  localparam logic [1:0] REG_MEDIUM_BASE = 2'd1;
  localparam logic [1:0] REG_LARGE_BASE  = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED  = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_FREED      = 3'd3,
    ST_OUTSIDE    = 3'd4,
    ST_ALREADY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CLS_SMALL  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LARGE  = 2'd2,
    CLS_NONE   = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    K_ALLOC = 2'd0,
    K_FREE  = 2'd1,
    K_FAIL  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    cls_t              cls;
    status_t           fail_status;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       start;
  } cmd_t;

endpackage

FILE: hw/rtl/scba_front.sv
module scba_front #(
  parameter int unsigned SMALL_BLOCKS  = scba_pkg::SMALL_BLOCKS_DEF,
  parameter int unsigned MEDIUM_BLOCKS = scba_pkg::MEDIUM_BLOCKS_DEF,
  parameter int unsigned LARGE_BLOCKS  = scba_pkg::LARGE_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             action,
  input  logic [31:0]      request_size,
  input  logic [31:0]      free_address,
  input  logic [31:0]      small_base,
  input  logic [31:0]      medium_base,
  input  logic [31:0]      large_base,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output scba_pkg::cmd_t   cmd
);

  localparam logic [47:0] SMALL_SPAN  = 48'(SMALL_BLOCKS)  << scba_pkg::SMALL_SHIFT;
  localparam logic [47:0] MEDIUM_SPAN = 48'(MEDIUM_BLOCKS) << scba_pkg::MEDIUM_SHIFT;
  localparam logic [47:0] LARGE_SPAN  = 48'(LARGE_BLOCKS)  << scba_pkg::LARGE_SHIFT;
  localparam logic [32:0] SMALL_LIM   = 33'd1 << scba_pkg::SMALL_SHIFT;
  localparam logic [32:0] MEDIUM_LIM  = 33'd1 << scba_pkg::MEDIUM_SHIFT;
  localparam logic [32:0] LARGE_LIM   = 33'd1 << scba_pkg::LARGE_SHIFT;

  logic        held;
  logic        act;
  logic [31:0] size;
  logic [31:0] addr;
  logic        accept;

  logic [31:0] d_s, d_m, d_l;
  logic        hit_s, hit_m, hit_l;

  assign busy   = held & q_full;
  assign accept = start & ~busy;
  assign push   = held & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept | (held & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= action;
      size <= request_size;
      addr <= free_address;
    end
  end

  assign d_s   = addr - small_base;
  assign d_m   = addr - medium_base;
  assign d_l   = addr - large_base;
  assign hit_s = (addr >= small_base)  && ({16'd0, d_s} < SMALL_SPAN);
  assign hit_m = (addr >= medium_base) && ({16'd0, d_m} < MEDIUM_SPAN);
  assign hit_l = (addr >= large_base)  && ({16'd0, d_l} < LARGE_SPAN);

  always_comb begin
    cmd             = '0;
    cmd.kind        = scba_pkg::K_FAIL;
    cmd.cls         = scba_pkg::CLS_NONE;
    cmd.fail_status = scba_pkg::ST_OUTSIDE;
    if (act == scba_pkg::ACT_ALLOC) begin
      cmd.kind = scba_pkg::K_ALLOC;
      if ({1'b0, size} <= SMALL_LIM) begin
        cmd.cls = scba_pkg::CLS_SMALL;
      end else if ({1'b0, size} <= MEDIUM_LIM) begin
        cmd.cls = scba_pkg::CLS_MEDIUM;
      end else if ({1'b0, size} <= LARGE_LIM) begin
        cmd.cls = scba_pkg::CLS_LARGE;
      end else begin
        cmd.kind        = scba_pkg::K_FAIL;
        cmd.fail_status = scba_pkg::ST_TOO_LARGE;
      end
    end else if (hit_s) begin
      cmd.kind  = scba_pkg::K_FREE;
      cmd.cls   = scba_pkg::CLS_SMALL;
      cmd.idx   = scba_pkg::IDX_W'(d_s >> scba_pkg::SMALL_SHIFT);
      cmd.start = small_base + ((d_s >> scba_pkg::SMALL_SHIFT) << scba_pkg::SMALL_SHIFT);
    end else if (hit_m) begin
      cmd.kind  = scba_pkg::K_FREE;
      cmd.cls   = scba_pkg::CLS_MEDIUM;
      cmd.idx   = scba_pkg::IDX_W'(d_m >> scba_pkg::MEDIUM_SHIFT);
      cmd.start = medium_base + ((d_m >> scba_pkg::MEDIUM_SHIFT) << scba_pkg::MEDIUM_SHIFT);
    end else if (hit_l) begin
      cmd.kind  = scba_pkg::K_FREE;
      cmd.cls   = scba_pkg::CLS_LARGE;
      cmd.idx   = scba_pkg::IDX_W'(d_l >> scba_pkg::LARGE_SHIFT);
      cmd.start = large_base + ((d_l >> scba_pkg::LARGE_SHIFT) << scba_pkg::LARGE_SHIFT);
    end
  end

endmodule

FILE: hw/rtl/scba_queue.sv
module scba_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  scba_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output scba_pkg::cmd_t  head
);

  scba_pkg::cmd_t slot [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= push_cmd;
  end

endmodule

FILE: hw/rtl/scba_pool.sv
module scba_pool #(
  parameter int unsigned BLOCKS = scba_pkg::SMALL_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [scba_pkg::ROW_W-1:0]    rd_row,
  output logic [31:0]                   rd_data,
  input  logic                          wr_en,
  input  logic [scba_pkg::ROW_W-1:0]    wr_row,
  input  logic [31:0]                   wr_data,
  input  logic                          cnt_inc,
  input  logic                          cnt_dec,
  output logic [scba_pkg::CNT_W-1:0]    count,
  output logic                          any_free,
  output logic [scba_pkg::ROW_W-1:0]    first_row
);

  localparam int unsigned ROWS      = (BLOCKS + 31) / 32;
  localparam int unsigned RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW        = $clog2(BLOCKS + 1);
  localparam int unsigned LAST_BITS = BLOCKS - (ROWS - 1) * 32;
  localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (32 - LAST_BITS);

  logic [31:0]   mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [ROWS-1:0] summary;
  logic [CW-1:0]   cnt;
  logic [31:0]     rd_q;
  logic            rd_valid_q;
  logic            rd_last_q;
  logic [RW-1:0]   ff_row;

  // a row never written reads back as its reset value: all its blocks free
  assign rd_data = rd_valid_q ? rd_q : (rd_last_q ? LAST_MASK : 32'hFFFF_FFFF);
  assign count   = scba_pkg::CNT_W'(cnt);

  // follow the summary bits directly so a write is seen by the very next pop
  assign any_free  = |summary;
  assign first_row = scba_pkg::ROW_W'(ff_row);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_row[RW-1:0]];
    end
    if (wr_en) begin
      mem[wr_row[RW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      summary    <= '1;
      cnt        <= CW'(BLOCKS);
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_row[RW-1:0]];
        rd_last_q  <= (rd_row[RW-1:0] == RW'(ROWS - 1));
      end
      if (wr_en) begin
        row_valid[wr_row[RW-1:0]] <= 1'b1;
        summary[wr_row[RW-1:0]]   <= |wr_data;
      end
      if (cnt_inc) cnt <= cnt + 1'b1;
      else if (cnt_dec) cnt <= cnt - 1'b1;
    end
  end

  always_comb begin
    ff_row = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (summary[i]) ff_row = RW'(i);
    end
  end

endmodule

FILE: hw/rtl/scba_back.sv
module scba_back #(
  parameter int unsigned SMALL_BLOCKS  = scba_pkg::SMALL_BLOCKS_DEF,
  parameter int unsigned MEDIUM_BLOCKS = scba_pkg::MEDIUM_BLOCKS_DEF,
  parameter int unsigned LARGE_BLOCKS  = scba_pkg::LARGE_BLOCKS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  scba_pkg::cmd_t  head,
  output logic            pop,
  input  logic [31:0]     small_base,
  input  logic [31:0]     medium_base,
  input  logic [31:0]     large_base,
  output logic            done,
  output logic [31:0]     block_address,
  output logic [2:0]      status,
  output logic [1:0]      pool_class,
  output logic [10:0]     pool_free_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                       state;
  state_t                       state_next;
  scba_pkg::cmd_t               cur;
  logic [scba_pkg::ROW_W-1:0]   cur_row;

  logic [31:0]                  rd_data [3];
  logic [scba_pkg::CNT_W-1:0]   cnt [3];
  logic [2:0]                   any_free;
  logic [scba_pkg::ROW_W-1:0]   first_row [3];
  logic [2:0]                   rd_en, wr_en, inc, dec;
  logic [scba_pkg::ROW_W-1:0]   rd_row;
  logic [31:0]                  wr_data;

  logic [1:0]                   hsel;
  logic [1:0]                   csel;
  logic                         direct;
  logic [31:0]                  word;
  logic [scba_pkg::BIT_W-1:0]   low_bit;
  logic [scba_pkg::BIT_W-1:0]   fbit;
  logic                         was_free;
  logic [scba_pkg::IDX_W-1:0]   aidx;
  logic [31:0]                  aaddr;
  logic [31:0]                  base_sel;
  logic [scba_pkg::CNT_W-1:0]   cnt_sel;

  scba_pool #(.BLOCKS(SMALL_BLOCKS)) u_small (
    .clk, .rst, .rd_en(rd_en[0]), .rd_row, .rd_data(rd_data[0]),
    .wr_en(wr_en[0]), .wr_row(cur_row), .wr_data,
    .cnt_inc(inc[0]), .cnt_dec(dec[0]), .count(cnt[0]),
    .any_free(any_free[0]), .first_row(first_row[0])
  );
  scba_pool #(.BLOCKS(MEDIUM_BLOCKS)) u_medium (
    .clk, .rst, .rd_en(rd_en[1]), .rd_row, .rd_data(rd_data[1]),
    .wr_en(wr_en[1]), .wr_row(cur_row), .wr_data,
    .cnt_inc(inc[1]), .cnt_dec(dec[1]), .count(cnt[1]),
    .any_free(any_free[1]), .first_row(first_row[1])
  );
  scba_pool #(.BLOCKS(LARGE_BLOCKS)) u_large (
    .clk, .rst, .rd_en(rd_en[2]), .rd_row, .rd_data(rd_data[2]),
    .wr_en(wr_en[2]), .wr_row(cur_row), .wr_data,
    .cnt_inc(inc[2]), .cnt_dec(dec[2]), .count(cnt[2]),
    .any_free(any_free[2]), .first_row(first_row[2])
  );

  assign hsel = (head.cls == scba_pkg::CLS_NONE) ? 2'd0 : head.cls;
  assign csel = (cur.cls == scba_pkg::CLS_NONE) ? 2'd0 : cur.cls;
  assign pop  = (state == S_IDLE) & ~q_empty;

  // fail beats and exhausted pools finish without touching the bitmap
  assign direct = (head.kind == scba_pkg::K_FAIL) ||
                  ((head.kind == scba_pkg::K_ALLOC) && !any_free[hsel]);

  assign rd_row = (head.kind == scba_pkg::K_ALLOC) ? first_row[hsel]
                : head.idx[scba_pkg::IDX_W-1:scba_pkg::BIT_W];

  always_comb begin
    rd_en = '0;
    if (pop && !direct) rd_en[hsel] = 1'b1;
  end

  assign word     = rd_data[csel];
  assign cnt_sel  = cnt[csel];
  assign fbit     = cur.idx[scba_pkg::BIT_W-1:0];
  assign was_free = word[fbit];

  always_comb begin
    low_bit = '0;
    for (int i = 31; i >= 0; i--) begin
      if (word[i]) low_bit = scba_pkg::BIT_W'(i);
    end
  end

  always_comb begin
    case (csel)
      2'd0:    base_sel = small_base;
      2'd1:    base_sel = medium_base;
      default: base_sel = large_base;
    endcase
  end

  assign aidx = {cur_row, low_bit};

  always_comb begin
    case (csel)
      2'd0:    aaddr = base_sel + (32'(aidx) << scba_pkg::SMALL_SHIFT);
      2'd1:    aaddr = base_sel + (32'(aidx) << scba_pkg::MEDIUM_SHIFT);
      default: aaddr = base_sel + (32'(aidx) << scba_pkg::LARGE_SHIFT);
    endcase
  end

  always_comb begin
    wr_en   = '0;
    inc     = '0;
    dec     = '0;
    wr_data = word;
    if (state == S_READ) begin
      if (cur.kind == scba_pkg::K_ALLOC) begin
        wr_data      = word & ~(32'd1 << low_bit);
        wr_en[csel]  = 1'b1;
        dec[csel]    = 1'b1;
      end else if (!was_free) begin
        wr_data      = word | (32'd1 << fbit);
        wr_en[csel]  = 1'b1;
        inc[csel]    = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (pop && !direct) state_next = S_READ;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (pop && direct) || (state == S_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= head;
      cur_row <= rd_row;
    end
    if (pop && direct) begin
      block_address   <= '0;
      pool_free_count <= '0;
      if (head.kind == scba_pkg::K_FAIL) begin
        status     <= head.fail_status;
        pool_class <= scba_pkg::CLS_NONE;
      end else begin
        status     <= scba_pkg::ST_EXHAUSTED;
        pool_class <= head.cls;
      end
    end else if (state == S_READ) begin
      pool_class <= cur.cls;
      if (cur.kind == scba_pkg::K_ALLOC) begin
        block_address   <= aaddr;
        status          <= scba_pkg::ST_ALLOCATED;
        pool_free_count <= 11'(cnt_sel - 1'b1);
      end else if (was_free) begin
        block_address   <= cur.start;
        status          <= scba_pkg::ST_ALREADY;
        pool_free_count <= 11'(cnt_sel);
      end else begin
        block_address   <= cur.start;
        status          <= scba_pkg::ST_FREED;
        pool_free_count <= 11'(cnt_sel + 1'b1);
      end
    end
  end

endmodule

FILE: hw/rtl/size_class_bitmap_allocator_unit.sv
// channel   | direction | handshake             | payload
// request   | in        | start & !busy         | action, request_size, free_address
// result    | out       | done (one cycle)      | block_address, status, pool_class,
//           |           |                       | pool_free_count
// config    | in        | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// A request passes the front, which classifies and range-checks it, and the queue; the
// back then pops it and reads the bitmap row in S_IDLE, and updates the row and count
// in S_READ. Rejects and exhausted pools skip the row access and S_READ.
// The back pops no new request while in S_READ: one read-modify-write on the bitmap at a time.
// Synchronous reset; bitmap rows are tracked by per-row valid bits, so no clearing pass.
// The receiver cannot stall; busy rises only when the front holds a beat and the
// two-entry queue is full.
module size_class_bitmap_allocator_unit #(
  parameter int unsigned SMALL_BLOCKS  = scba_pkg::SMALL_BLOCKS_DEF,
  parameter int unsigned MEDIUM_BLOCKS = scba_pkg::MEDIUM_BLOCKS_DEF,
  parameter int unsigned LARGE_BLOCKS  = scba_pkg::LARGE_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [31:0] request_size,
  input  logic [31:0] free_address,
  output logic        done,
  output logic [31:0] block_address,
  output logic [2:0]  status,
  output logic [1:0]  pool_class,
  output logic [10:0] pool_free_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]    small_base, medium_base, large_base;
  logic           push, pop, q_full, q_empty;
  scba_pkg::cmd_t cmd, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_base  <= scba_pkg::SMALL_BASE_RST;
      medium_base <= scba_pkg::MEDIUM_BASE_RST;
      large_base  <= scba_pkg::LARGE_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scba_pkg::REG_SMALL_BASE:  small_base  <= cfg_data;
        scba_pkg::REG_MEDIUM_BASE: medium_base <= cfg_data;
        scba_pkg::REG_LARGE_BASE:  large_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  scba_front #(
    .SMALL_BLOCKS(SMALL_BLOCKS), .MEDIUM_BLOCKS(MEDIUM_BLOCKS), .LARGE_BLOCKS(LARGE_BLOCKS)
  ) u_front (
    .clk, .rst, .start, .action, .request_size, .free_address,
    .small_base, .medium_base, .large_base, .q_full, .busy, .push, .cmd
  );

  scba_queue u_queue (
    .clk, .rst, .push, .push_cmd(cmd), .pop, .full(q_full), .empty(q_empty), .head
  );

  scba_back #(
    .SMALL_BLOCKS(SMALL_BLOCKS), .MEDIUM_BLOCKS(MEDIUM_BLOCKS), .LARGE_BLOCKS(LARGE_BLOCKS)
  ) u_back (
    .clk, .rst, .q_empty, .head, .pop, .small_base, .medium_base, .large_base,
    .done, .block_address, .status, .pool_class, .pool_free_count
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("push into full queue");

  a_alloc_has_pool: assert property (@(posedge clk) disable iff (rst)
    (done && status == scba_pkg::ST_ALLOCATED) |-> pool_class != scba_pkg::CLS_NONE)
    else $error("allocation without pool");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == scba_pkg::ST_TOO_LARGE || status == scba_pkg::ST_OUTSIDE))
      |-> (block_address == 32'd0 && pool_class == scba_pkg::CLS_NONE))
    else $error("reject beat carries data");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

endmodule
